// ===== hw/rtl/long_press_detector_assert.svh =====
// ----------------------------------------------------------------------------
// long_press_detector_assert.svh
// assertion macros used by the long press detector checker
// ----------------------------------------------------------------------------
`ifndef LONG_PRESS_DETECTOR_ASSERT_SVH
`define LONG_PRESS_DETECTOR_ASSERT_SVH

// clocked assertion, disabled while reset is asserted
`define LPD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define LPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/lpd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpd_pkg
// types and constants of the long press detector
// ----------------------------------------------------------------------------
package lpd_pkg;

	// detector phase, also the phase_out code
	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_PRESSED = 2'd1,
		PH_WAIT    = 2'd2
	} phase_t;

	// register indexes (paddr[3:2])
	typedef enum logic [1:0] {
		REG_HOLD_TIME       = 2'd0,
		REG_DEBOUNCE        = 2'd1,
		REG_RELEASE_TIMEOUT = 2'd2
	} reg_idx_t;

	localparam int unsigned ADDR_W = 4;

	// led patterns
	localparam logic [15:0] HELD_PATTERN  = 16'hAAAA;
	localparam logic [15:0] SOLID_PATTERN = 16'hFFFF;

	// register reset values
	localparam logic [15:0] HOLD_TIME_RST       = 16'd5000;
	localparam logic [7:0]  DEBOUNCE_RST        = 8'd50;
	localparam logic [15:0] RELEASE_TIMEOUT_RST = 16'd10000;

	localparam logic [7:0] POLLS_MAX = 8'd255;

endpackage

// ===== hw/rtl/lpd_in_if.sv =====
// ----------------------------------------------------------------------------
// lpd_in_if
// poll channel: button level, timestamp and current led pattern
// ----------------------------------------------------------------------------
interface lpd_in_if;
	logic        valid;
	logic        ready;
	logic        pressed;
	logic [31:0] now_ms;
	logic [15:0] current_blink;

	modport source (output valid, output pressed, output now_ms, output current_blink,
		input ready);
	modport sink (input valid, input pressed, input now_ms, input current_blink,
		output ready);
endinterface

// ===== hw/rtl/lpd_out_if.sv =====
// ----------------------------------------------------------------------------
// lpd_out_if
// result channel: led write, pulses and phase
// ----------------------------------------------------------------------------
interface lpd_out_if;
	logic        valid;
	logic        ready;
	logic        blink_write;
	logic [15:0] blink_out;
	logic        set_force_ap;
	logic        reboot;
	logic [1:0]  phase_out;

	modport source (output valid, output blink_write, output blink_out,
		output set_force_ap, output reboot, output phase_out, input ready);
	modport sink (input valid, input blink_write, input blink_out,
		input set_force_ap, input reboot, input phase_out, output ready);
endinterface

// ===== hw/rtl/long_press_detector.sv =====
// ----------------------------------------------------------------------------
// long_press_detector
// button long press detector with release debounce
// ----------------------------------------------------------------------------
// Usage:
// - poll (valid/ready sink) takes one poll per transaction: button level,
//   millisecond timestamp and the led pattern in use.
// - result (valid/ready source) returns exactly one transaction per poll:
//   led write and pattern, set_force_ap and reboot pulses, phase after it.
// - the apb port holds hold_time_ms (0x0), debounce_polls (0x4) and
//   release_timeout_ms (0x8); write only while no poll is in flight.
// Path: a poll passes the input register, then the result register, before
//   its result transaction is offered. Throughput: one poll per cycle while
//   the result is taken; the state update is two 32-bit subtracts and
//   compares plus an 8-bit counter.
// Reset: phase goes to idle, timestamps, saved pattern and counter to zero,
//   registers to their defaults; both channels are empty.
// Stall: while result is held, one more poll is taken into the input
//   register, then poll.ready drops until the result transaction completes.
// ----------------------------------------------------------------------------
module long_press_detector (
	input  logic                          clk,
	input  logic                          arst_n,
	lpd_in_if.sink                        poll,
	lpd_out_if.source                     result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lpd_pkg::ADDR_W-1:0]    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	// configuration registers
	logic [15:0] hold_time_q;
	logic [7:0]  debounce_q;
	logic [15:0] release_timeout_q;

	// detector state
	lpd_pkg::phase_t phase_q, phase_d;
	logic [31:0] press_start_q;
	logic [31:0] wait_start_q;
	logic [15:0] saved_pattern_q;
	logic [7:0]  released_polls_q, released_polls_d;

	// input stage
	logic        valid_s1;
	logic        pressed_s1;
	logic [31:0] now_s1;
	logic [15:0] cur_s1;

	// result register
	logic        valid_q;
	logic        bw_q, ap_q, rb_q;
	logic [15:0] bo_q;
	logic [1:0]  phase_out_q;

	logic        advance;
	logic        cfg_wr;
	logic [1:0]  reg_sel;
	logic [31:0] held_ms, wait_ms;
	logic        hold_done, wait_done;
	logic [7:0]  polls_inc;
	logic        bw_d, ap_d, rb_d;
	logic [15:0] bo_d;

	assign advance = valid_s1 && (!valid_q || result.ready);
	assign poll.ready = !valid_s1 || advance;

	// apb access
	assign pready  = 1'b1;
	assign reg_sel = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		case (reg_sel)
			lpd_pkg::REG_HOLD_TIME:       prdata = {16'd0, hold_time_q};
			lpd_pkg::REG_DEBOUNCE:        prdata = {24'd0, debounce_q};
			lpd_pkg::REG_RELEASE_TIMEOUT: prdata = {16'd0, release_timeout_q};
			default:                      prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_time_q       <= lpd_pkg::HOLD_TIME_RST;
			debounce_q        <= lpd_pkg::DEBOUNCE_RST;
			release_timeout_q <= lpd_pkg::RELEASE_TIMEOUT_RST;
		end else if (cfg_wr) begin
			case (reg_sel)
				lpd_pkg::REG_HOLD_TIME:       hold_time_q       <= pwdata[15:0];
				lpd_pkg::REG_DEBOUNCE:        debounce_q        <= pwdata[7:0];
				lpd_pkg::REG_RELEASE_TIMEOUT: release_timeout_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			valid_s1 <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll.ready && poll.valid) begin
			pressed_s1 <= poll.pressed;
			now_s1     <= poll.now_ms;
			cur_s1     <= poll.current_blink;
		end
	end

	// elapsed times, wrapping modulo 2^32
	assign held_ms   = now_s1 - press_start_q;
	assign wait_ms   = now_s1 - wait_start_q;
	assign hold_done = held_ms >= {16'd0, hold_time_q};
	assign wait_done = wait_ms >= {16'd0, release_timeout_q};
	assign polls_inc = (released_polls_q < lpd_pkg::POLLS_MAX) ?
		released_polls_q + 8'd1 : released_polls_q;

	// next phase and release counter
	always_comb begin
		phase_d          = phase_q;
		released_polls_d = released_polls_q;
		case (phase_q)
			lpd_pkg::PH_PRESSED: begin
				if (!pressed_s1) begin
					released_polls_d = polls_inc;
					if (polls_inc >= debounce_q) begin
						phase_d          = lpd_pkg::PH_IDLE;
						released_polls_d = 8'd0;
					end
				end else begin
					released_polls_d = 8'd0;
					if (hold_done) phase_d = lpd_pkg::PH_WAIT;
				end
			end
			lpd_pkg::PH_WAIT: begin
				if (!pressed_s1 || wait_done) phase_d = lpd_pkg::PH_IDLE;
			end
			default: begin
				phase_d = lpd_pkg::PH_IDLE;
				if (pressed_s1) begin
					phase_d          = lpd_pkg::PH_PRESSED;
					released_polls_d = 8'd0;
				end
			end
		endcase
	end

	// result fields
	always_comb begin
		bw_d = 1'b0;
		bo_d = 16'd0;
		ap_d = 1'b0;
		rb_d = 1'b0;
		case (phase_q)
			lpd_pkg::PH_PRESSED: begin
				if (!pressed_s1) begin
					if (polls_inc >= debounce_q) begin
						bw_d = 1'b1;
						bo_d = saved_pattern_q;
					end
				end else if (hold_done) begin
					ap_d = 1'b1;
					bw_d = 1'b1;
					bo_d = lpd_pkg::SOLID_PATTERN;
				end else begin
					bw_d = 1'b1;
					bo_d = lpd_pkg::HELD_PATTERN;
				end
			end
			lpd_pkg::PH_WAIT: begin
				rb_d = !pressed_s1 || wait_done;
			end
			default: ;
		endcase
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= lpd_pkg::PH_IDLE;
			press_start_q    <= 32'd0;
			wait_start_q     <= 32'd0;
			saved_pattern_q  <= 16'd0;
			released_polls_q <= 8'd0;
		end else if (advance) begin
			phase_q          <= phase_d;
			released_polls_q <= released_polls_d;
			if (phase_q != lpd_pkg::PH_PRESSED && phase_q != lpd_pkg::PH_WAIT
				&& pressed_s1) begin
				press_start_q   <= now_s1;
				saved_pattern_q <= cur_s1;
			end
			if (phase_q == lpd_pkg::PH_PRESSED && pressed_s1 && hold_done) begin
				wait_start_q <= now_s1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			bw_q        <= bw_d;
			bo_q        <= bo_d;
			ap_q        <= ap_d;
			rb_q        <= rb_d;
			phase_out_q <= phase_d;
		end
	end

	assign result.valid        = valid_q;
	assign result.blink_write  = bw_q;
	assign result.blink_out    = bo_q;
	assign result.set_force_ap = ap_q;
	assign result.reboot       = rb_q;
	assign result.phase_out    = phase_out_q;

endmodule

// ===== hw/rtl/lpd_checker.sv =====
// ----------------------------------------------------------------------------
// lpd_checker
// port level checks of the long press detector result channel
// ----------------------------------------------------------------------------
`include "long_press_detector_assert.svh"

module lpd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        blink_write,
	input logic [15:0] blink_out,
	input logic        set_force_ap,
	input logic        reboot,
	input logic [1:0]  phase_out
);

	// long press shows solid led and enters the wait phase
	`LPD_ASSERT(a_force_ap, clk, arst_n, out_valid && set_force_ap |-> blink_write && blink_out == lpd_pkg::SOLID_PATTERN && phase_out == lpd_pkg::PH_WAIT, "force ap result without solid led or wait phase")

	// reboot ends in idle with no led write
	`LPD_ASSERT(a_reboot, clk, arst_n, out_valid && reboot |-> !blink_write && !set_force_ap && phase_out == lpd_pkg::PH_IDLE, "reboot result not idle or with led write")

	// a write while still pressed is always the held pattern
	`LPD_ASSERT(a_held, clk, arst_n, out_valid && blink_write && phase_out == lpd_pkg::PH_PRESSED |-> blink_out == lpd_pkg::HELD_PATTERN, "pressed phase led write is not the held pattern")

	// stalled result transaction holds
	`LPD_ASSERT(a_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(phase_out) && $stable(blink_out), "stalled result changed")

endmodule

bind long_press_detector lpd_checker u_lpd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.blink_write  (result.blink_write),
	.blink_out    (result.blink_out),
	.set_force_ap (result.set_force_ap),
	.reboot       (result.reboot),
	.phase_out    (result.phase_out)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// long press detector: two short directed runs, then random press and release
// episodes under several register settings. Each result transaction is
// compared field by field with a prediction made when its poll is accepted.
// ----------------------------------------------------------------------------
module testbench;

	// one expected or observed result transaction
	typedef struct packed {
		logic        blink_write;
		logic [15:0] blink_out;
		logic        set_force_ap;
		logic        reboot;
		logic [1:0]  phase_out;
	} led_result_t;

	// press state tracker and queue of expected led results
	class press_tracker;
		led_result_t     expected_results[$];
		int              errors;
		logic [15:0]     hold_ms;
		logic [7:0]      debounce;
		logic [15:0]     timeout_ms;
		lpd_pkg::phase_t phase;
		logic [31:0]     press_start;
		logic [31:0]     wait_start;
		logic [15:0]     saved_blink;
		logic [7:0]      released;

		function new();
			errors      = 0;
			hold_ms     = lpd_pkg::HOLD_TIME_RST;
			debounce    = lpd_pkg::DEBOUNCE_RST;
			timeout_ms  = lpd_pkg::RELEASE_TIMEOUT_RST;
			phase       = lpd_pkg::PH_IDLE;
			press_start = '0;
			wait_start  = '0;
			saved_blink = '0;
			released    = '0;
		endfunction

		function void set_reg(lpd_pkg::reg_idx_t idx, logic [31:0] value);
			case (idx)
				lpd_pkg::REG_HOLD_TIME:       hold_ms = value[15:0];
				lpd_pkg::REG_DEBOUNCE:        debounce = value[7:0];
				lpd_pkg::REG_RELEASE_TIMEOUT: timeout_ms = value[15:0];
				default: ;
			endcase
		endfunction

		// advance the press state by one poll and queue its result
		function void note_poll(logic btn, logic [31:0] now, logic [15:0] cur);
			led_result_t r;
			logic [31:0] held_for;
			logic [31:0] waited_for;
			r          = '0;
			held_for   = now - press_start;
			waited_for = now - wait_start;
			case (phase)
				lpd_pkg::PH_PRESSED: begin
					if (!btn) begin
						// release counts only after enough released polls
						if (released != lpd_pkg::POLLS_MAX)
							released++;
						if (released >= debounce) begin
							phase         = lpd_pkg::PH_IDLE;
							r.blink_write = 1'b1;
							r.blink_out   = saved_blink;
							released      = '0;
						end
					end else begin
						released      = '0;
						r.blink_write = 1'b1;
						if (held_for >= {16'd0, hold_ms}) begin
							r.set_force_ap = 1'b1;
							phase          = lpd_pkg::PH_WAIT;
							wait_start     = now;
							r.blink_out    = lpd_pkg::SOLID_PATTERN;
						end else begin
							r.blink_out = lpd_pkg::HELD_PATTERN;
						end
					end
				end
				lpd_pkg::PH_WAIT: begin
					if (!btn || waited_for >= {16'd0, timeout_ms}) begin
						r.reboot = 1'b1;
						phase    = lpd_pkg::PH_IDLE;
					end
				end
				default: begin
					// press in idle saves the pattern and start time, with no led write
					phase = lpd_pkg::PH_IDLE;
					if (btn) begin
						phase       = lpd_pkg::PH_PRESSED;
						press_start = now;
						released    = '0;
						saved_blink = cur;
					end
				end
			endcase
			r.phase_out = phase;
			expected_results.push_back(r);
		endfunction

		function void check_led_result(led_result_t got);
			led_result_t want;
			if (expected_results.size() == 0) begin
				$error("result transaction with no poll outstanding");
				errors++;
				return;
			end
			want = expected_results.pop_front();
			if (got.blink_write !== want.blink_write) begin
				$error("blink_write: expected %0d, actual %0d", want.blink_write, got.blink_write);
				errors++;
			end
			if (got.blink_out !== want.blink_out) begin
				$error("blink_out: expected %h, actual %h", want.blink_out, got.blink_out);
				errors++;
			end
			if (got.set_force_ap !== want.set_force_ap) begin
				$error("set_force_ap: expected %0d, actual %0d", want.set_force_ap,
					got.set_force_ap);
				errors++;
			end
			if (got.reboot !== want.reboot) begin
				$error("reboot: expected %0d, actual %0d", want.reboot, got.reboot);
				errors++;
			end
			if (got.phase_out !== want.phase_out) begin
				$error("phase_out: expected %0d, actual %0d", want.phase_out, got.phase_out);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [lpd_pkg::ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	logic        result_ready = 1'b0;
	logic        gaps_on = 1'b1;
	int          stall_requests = 0;
	int          stall_served = 0;
	int          stall_left = 0;
	int          idle_left = 0;
	logic [31:0] clock_ms = '0;

	press_tracker led_tracker;

	lpd_in_if  poll_if();
	lpd_out_if result_if();

	assign result_if.ready = result_ready;

	long_press_detector u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.poll    (poll_if),
		.result  (result_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// result side: check transactions, long hold-off on request, random idle bursts
	always @(posedge clk) begin
		if (arst_n && result_if.valid === 1'b1 && result_ready)
			led_tracker.check_led_result('{result_if.blink_write, result_if.blink_out,
				result_if.set_force_ap, result_if.reboot, result_if.phase_out});
		if (stall_left > 0) begin
			stall_left   <= stall_left - 1;
			result_ready <= 1'b0;
		end else if (stall_served != stall_requests) begin
			stall_served <= stall_served + 1;
			stall_left   <= 40;
			result_ready <= 1'b0;
		end else if (idle_left > 0) begin
			idle_left    <= idle_left - 1;
			result_ready <= 1'b0;
		end else if (gaps_on && $urandom_range(0, 5) == 0) begin
			idle_left    <= $urandom_range(0, 3);
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	// offer one poll, with an occasional idle burst first, and wait for the transaction
	task automatic send_poll(input logic btn, input logic [31:0] now, input logic [15:0] cur);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			poll_if.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		poll_if.valid         <= 1'b1;
		poll_if.pressed       <= btn;
		poll_if.now_ms        <= now;
		poll_if.current_blink <= cur;
		do @(posedge clk); while (poll_if.ready !== 1'b1);
		led_tracker.note_poll(btn, now, cur);
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain();
		poll_if.valid <= 1'b0;
		while (led_tracker.expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// apb write: setup and access phases, then back to idle
	task automatic apb_write(input lpd_pkg::reg_idx_t idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		led_tracker.set_reg(idx, value);
		@(posedge clk);
	endtask

	task automatic write_config(input logic [15:0] hold, input logic [7:0] deb,
		input logic [15:0] timeout);
		apb_write(lpd_pkg::REG_HOLD_TIME, {16'd0, hold});
		apb_write(lpd_pkg::REG_DEBOUNCE, {24'd0, deb});
		apb_write(lpd_pkg::REG_RELEASE_TIMEOUT, {16'd0, timeout});
	endtask

	// random press episodes: mostly held runs followed by releases, some bounce and noise
	task automatic press_episodes(input int budget, input int unsigned step_max);
		int sent;
		int kind;
		int run_len;
		int deb;
		sent = 0;
		while (sent < budget) begin
			kind = $urandom_range(0, 7);
			deb  = led_tracker.debounce;
			if (kind == 0) begin
				// noise: random levels and timestamps
				run_len = $urandom_range(1, 3);
				repeat (run_len) begin
					clock_ms = $urandom;
					send_poll(1'($urandom_range(0, 1)), clock_ms, 16'($urandom));
					sent++;
				end
			end else begin
				// kind 1 starts near the top, so the timestamp may wrap during this hold
				if (kind == 1)
					clock_ms = 32'hFFFF_FFFF - $urandom_range(0, step_max * 4);
				run_len = $urandom_range(1, 16);
				repeat (run_len) begin
					clock_ms += $urandom_range(0, step_max);
					send_poll(1'b1, clock_ms, 16'($urandom));
					sent++;
				end
				// short release of at most deb polls is a bounce unless it reaches deb, otherwise long enough to be accepted
				if (kind == 2)
					run_len = $urandom_range(1, deb);
				else
					run_len = $urandom_range(deb, deb + 3);
				repeat (run_len) begin
					clock_ms += $urandom_range(0, step_max);
					send_poll(1'b0, clock_ms, 16'($urandom));
					sent++;
				end
			end
		end
	endtask

	// run limit
	initial begin
		#300us;
		$display("FAIL long_press_detector");
		$finish;
	end

	// stimulus
	initial begin
		led_tracker           = new();
		arst_n                = 1'b0;
		psel                  = 1'b0;
		penable               = 1'b0;
		pwrite                = 1'b0;
		paddr                 = '0;
		pwdata                = '0;
		poll_if.valid         = 1'b0;
		poll_if.pressed       = 1'b0;
		poll_if.now_ms        = '0;
		poll_if.current_blink = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero hold, debounce and timeout: each event fires on the first poll that can trigger it
		write_config(16'd0, 8'd0, 16'd0);
		send_poll(1'b0, 32'h0000_0000, 16'h0000);
		send_poll(1'b1, 32'hFFFF_FFFF, 16'hFFFF);
		send_poll(1'b0, 32'h0000_0000, 16'h0000);
		send_poll(1'b1, 32'h0000_0000, 16'h0000);
		send_poll(1'b1, 32'h0000_0000, 16'h1234);
		send_poll(1'b1, 32'h0000_0000, 16'h4321);
		send_poll(1'b1, 32'd100, 16'h5555);
		send_poll(1'b1, 32'd100, 16'h0F0F);
		send_poll(1'b0, 32'd100, 16'hF0F0);
		drain();

		// small settings: bounce, wrap across zero, hold then timeout
		write_config(16'd3, 8'd2, 16'd5);
		send_poll(1'b1, 32'hFFFF_FFFE, 16'h1357);
		send_poll(1'b1, 32'hFFFF_FFFF, 16'h0000);
		send_poll(1'b0, 32'hFFFF_FFFF, 16'hFFFF);
		send_poll(1'b1, 32'h0000_0000, 16'h0000);
		send_poll(1'b0, 32'h0000_0000, 16'h0000);
		send_poll(1'b0, 32'h0000_0001, 16'h0000);
		send_poll(1'b1, 32'd10, 16'h2468);
		send_poll(1'b1, 32'd13, 16'h0000);
		send_poll(1'b1, 32'd17, 16'h0000);
		send_poll(1'b1, 32'd18, 16'h0000);
		send_poll(1'b0, 32'd20, 16'hFFFF);
		drain();

		// lowest nonzero settings, with a long result hold-off so the input stalls
		write_config(16'd1, 8'd1, 16'd1);
		stall_requests <= stall_requests + 1;
		press_episodes(50, 1);
		drain();

		// highest settings, including a full 255-poll release
		write_config(16'hFFFF, 8'd255, 16'hFFFF);
		press_episodes(100, 16000);
		drain();

		// reset values
		write_config(lpd_pkg::HOLD_TIME_RST, lpd_pkg::DEBOUNCE_RST,
			lpd_pkg::RELEASE_TIMEOUT_RST);
		press_episodes(40, 2500);
		drain();

		// random mid settings, last stretch without idling
		write_config(16'($urandom_range(2, 40)), 8'($urandom_range(1, 6)),
			16'($urandom_range(2, 40)));
		press_episodes(30, 8);
		drain();
		gaps_on <= 1'b0;
		press_episodes(30, 8);
		drain();

		repeat (10) @(posedge clk);
		if (led_tracker.errors == 0)
			$display("PASS long_press_detector");
		else
			$display("FAIL long_press_detector");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/lpd_pkg.sv
hw/rtl/lpd_in_if.sv
hw/rtl/lpd_out_if.sv
hw/rtl/long_press_detector.sv
hw/rtl/lpd_checker.sv
dv/testbench.sv
